// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the timer slot table.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== hw/rtl/ptst_pkg.sv =====
// Package of the periodic timer slot table: codes, states and control structs.
// No dependencies.
package ptst_pkg;

    localparam int IN_ID_W  = 16;
    localparam int OUT_ID_W = 16;
    localparam int PERIOD_W = 16;
    localparam int KIND_W   = 3;
    localparam int OP_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_REGISTER = 2'd1,
        OP_ENABLE   = 2'd2,
        OP_NOP      = 2'd3
    } t_opcode;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED        = 3'd0,
        KIND_DONE         = 3'd1,
        KIND_REGISTERED   = 3'd2,
        KIND_OUT_OF_SLOTS = 3'd3,
        KIND_ENABLE_DONE  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture the input item
        logic prime;   // start the scan at slot zero
        logic step;    // handle the current slot
        logic finish;  // emit the closing result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_nop;     // incoming item is the unused opcode
        logic needs_out;  // current slot produces a result
        logic found;      // lookup matched the current slot
        logic last_slot;  // current slot is the final one
        logic out_free;   // output register can take a result
    } t_status;

endpackage

// ===== hw/rtl/periodic_timer_slot_table_core.sv =====
// Top level of the periodic timer slot table: controller plus datapath.
// Depends on ptst_pkg, ptst_ctrl, ptst_datapath (ptst_ram) and assert_macros.svh.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------
//   in      | input     | i_in_valid / o_in_ready   | opcode, timer_id, period_ticks,
//           |           |                           | enable_value
//   out     | output    | o_out_valid / i_out_ready | kind, fired_id, last
//
// A tick runs accept, a prime of the slot RAM read, every slot in turn and the
// done item. A register or enable lookup stops at the first slot that matches
// (empty or holding the id), or scans every slot and closes with a result when
// nothing matches. The slot RAM's single read port sets the one-slot-a-cycle
// pace while no result stalls the scan.
// Reset clears the per-slot valid bits at once; no clearing sweep runs.
// A result that is not taken stalls the scan on the slot that wants to
// report; the next item is accepted while the last result still waits.
`include "assert_macros.svh"

module periodic_timer_slot_table_core #(
    parameter int SLOT_COUNT = 10,
    parameter int ID_BITS    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ptst_pkg::OP_W-1:0]       i_opcode,
    input  logic [ptst_pkg::IN_ID_W-1:0]    i_timer_id,
    input  logic [ptst_pkg::PERIOD_W-1:0]   i_period_ticks,
    input  logic                            i_enable_value,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ptst_pkg::KIND_W-1:0]     o_kind,
    output logic [ptst_pkg::OUT_ID_W-1:0]   o_fired_id,
    output logic                            o_last
);
    ptst_pkg::t_cmd    cmd;
    ptst_pkg::t_status status;

    // sequencer: one state per phase of an item
    ptst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    // slot storage, per-slot update and result register
    ptst_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .ID_BITS    (ID_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_opcode       (i_opcode),
        .i_timer_id     (i_timer_id),
        .i_period_ticks (i_period_ticks),
        .i_enable_value (i_enable_value),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_fired_id     (o_fired_id),
        .o_last         (o_last)
    );

    // a slot result is only loaded when the output register has room
    `ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, cmd.step && status.needs_out, status.out_free)
    // the datapath is quiet while the block waits for an item
    `ASSERT_IMPLY(a_idle_quiet, i_clk, i_rst_n, o_in_ready, !(cmd.step || cmd.finish || cmd.prime))
    // a real item makes the block busy in the next cycle
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready && !status.in_nop, !o_in_ready)
    // fired items never close a tick; every other kind closes its item
    `ASSERT_IMPLY(a_fired_not_last, i_clk, i_rst_n, o_out_valid && (o_kind == ptst_pkg::KIND_FIRED), !o_last)
endmodule

// ===== hw/rtl/ptst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== hw/rtl/ptst_ctrl.sv =====
// Sequencer of the timer slot table: accept, prime, per-slot scan, finish.
// Depends on ptst_pkg.
module ptst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  ptst_pkg::t_status i_status,
    output ptst_pkg::t_cmd    o_cmd,
    output logic              o_in_ready
);
    ptst_pkg::t_state r_state;
    ptst_pkg::t_state n_state;
    logic             stall;

    assign stall = i_status.needs_out && !i_status.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptst_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptst_pkg::ST_IDLE: begin
                if (i_in_valid && !i_status.in_nop) begin
                    n_state = ptst_pkg::ST_PRIME;
                end
            end
            ptst_pkg::ST_PRIME: begin
                n_state = ptst_pkg::ST_SCAN;
            end
            ptst_pkg::ST_SCAN: begin
                if (!stall) begin
                    if (i_status.found) begin
                        n_state = ptst_pkg::ST_IDLE;
                    end else if (i_status.last_slot) begin
                        n_state = ptst_pkg::ST_FINISH;
                    end
                end
            end
            ptst_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = ptst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ptst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ptst_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ptst_pkg::ST_PRIME: begin
                o_cmd.prime = 1'b1;
            end
            ptst_pkg::ST_SCAN: begin
                o_cmd.step = !stall;
            end
            ptst_pkg::ST_FINISH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end
endmodule

// ===== hw/rtl/ptst_datapath.sv =====
// Datapath of the timer slot table: slot RAM, valid bits, slot update, result register.
// Depends on ptst_pkg and ptst_ram.
module ptst_datapath #(
    parameter int SLOT_COUNT = 10,
    parameter int ID_BITS    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ptst_pkg::t_cmd                  i_cmd,
    output ptst_pkg::t_status               o_status,
    input  logic [ptst_pkg::OP_W-1:0]       i_opcode,
    input  logic [ptst_pkg::IN_ID_W-1:0]    i_timer_id,
    input  logic [ptst_pkg::PERIOD_W-1:0]   i_period_ticks,
    input  logic                            i_enable_value,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [ptst_pkg::KIND_W-1:0]     o_kind,
    output logic [ptst_pkg::OUT_ID_W-1:0]   o_fired_id,
    output logic                            o_last
);
    localparam int AW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW     = ptst_pkg::PERIOD_W;
    localparam int WORD_W = ID_BITS + PW + COUNT_BITS + 1;
    localparam int CMP_W  = (COUNT_BITS > PW) ? COUNT_BITS : PW;
    localparam logic [AW-1:0] LAST_IDX = AW'(SLOT_COUNT - 1);

    // captured item
    ptst_pkg::t_opcode     r_op;
    logic [ID_BITS-1:0]    r_key;
    logic [PW-1:0]         r_period;
    logic                  r_en;

    logic [AW-1:0]         r_idx;
    logic [AW-1:0]         rd_addr;
    logic [SLOT_COUNT-1:0] r_valid;

    logic [WORD_W-1:0]     rd_word;
    logic [WORD_W-1:0]     wr_word;
    logic                  wr_en;

    logic [ID_BITS-1:0]    s_id;
    logic [PW-1:0]         s_per;
    logic [COUNT_BITS-1:0] s_cnt;
    logic                  s_en;
    logic [COUNT_BITS-1:0] s_cnt_inc;
    logic [COUNT_BITS-1:0] s_cnt_next;
    logic                  fire;
    logic                  match;
    logic                  is_tick;
    logic                  last_slot;
    logic                  out_free;
    logic                  out_load;

    // output register
    logic                        r_out_valid;
    ptst_pkg::t_kind             r_kind;
    logic [ID_BITS-1:0]          r_fired_id;
    logic                        r_last;
    ptst_pkg::t_kind             n_kind;
    logic [ID_BITS-1:0]          n_fired_id;
    logic                        n_last;

    ptst_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (wr_word),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= ptst_pkg::t_opcode'(i_opcode);
            r_key    <= ID_BITS'(i_timer_id);
            r_period <= i_period_ticks;
            r_en     <= i_enable_value;
        end
        if (i_cmd.prime) begin
            r_idx <= '0;
        end else if (i_cmd.step && !last_slot) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // read one slot ahead while stepping, hold the current slot while stalled
    always_comb begin
        if (i_cmd.prime) begin
            rd_addr = '0;
        end else if (i_cmd.step && !last_slot) begin
            rd_addr = r_idx + AW'(1);
        end else begin
            rd_addr = r_idx;
        end
    end

    // slot never written reads as empty, count zero, disabled
    always_comb begin
        {s_id, s_per, s_cnt, s_en} = rd_word;
        if (!r_valid[r_idx]) begin
            s_id  = '0;
            s_cnt = '0;
            s_en  = 1'b0;
        end
    end

    assign is_tick    = (r_op == ptst_pkg::OP_TICK);
    assign last_slot  = (r_idx == LAST_IDX);
    assign fire       = (s_id != '0) && (CMP_W'(s_per) <= CMP_W'(s_cnt)) && s_en;
    assign match      = (s_id == '0) || (s_id == r_key);
    assign s_cnt_inc  = (s_cnt != '1) ? (s_cnt + COUNT_BITS'(1)) : s_cnt;
    assign s_cnt_next = fire ? {COUNT_BITS{1'b0}} : s_cnt_inc;

    always_comb begin
        case (r_op)
            ptst_pkg::OP_TICK: begin
                wr_word = {s_id, s_per, s_cnt_next, s_en};
            end
            ptst_pkg::OP_REGISTER: begin
                wr_word = {r_key, r_period, {COUNT_BITS{1'b0}}, 1'b1};
            end
            default: begin
                wr_word = {s_id, s_per, s_cnt, r_en};
            end
        endcase
    end

    assign wr_en = i_cmd.step && (is_tick || match);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[r_idx] <= 1'b1;
        end
    end

    // result selection
    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = (i_cmd.step && (is_tick ? fire : match)) || i_cmd.finish;

    always_comb begin
        n_fired_id = '0;
        n_last     = 1'b1;
        case (r_op)
            ptst_pkg::OP_TICK: begin
                n_kind = i_cmd.finish ? ptst_pkg::KIND_DONE : ptst_pkg::KIND_FIRED;
                if (!i_cmd.finish) begin
                    n_fired_id = s_id;
                    n_last     = 1'b0;
                end
            end
            ptst_pkg::OP_REGISTER: begin
                n_kind = i_cmd.finish ? ptst_pkg::KIND_OUT_OF_SLOTS
                                      : ptst_pkg::KIND_REGISTERED;
            end
            default: begin
                n_kind = ptst_pkg::KIND_ENABLE_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_kind     <= n_kind;
            r_fired_id <= n_fired_id;
            r_last     <= n_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_fired_id  = ptst_pkg::OUT_ID_W'(r_fired_id);
    assign o_last      = r_last;

    assign o_status.in_nop    = (ptst_pkg::t_opcode'(i_opcode) == ptst_pkg::OP_NOP);
    assign o_status.needs_out = is_tick ? fire : match;
    assign o_status.found     = !is_tick && match;
    assign o_status.last_slot = last_slot;
    assign o_status.out_free  = out_free;
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for periodic_timer_slot_table_core: a small checker class keeps a behavioral slot
// table that predicts every result item and compares them. Depends on ptst_pkg and the core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS   = 10;
    localparam int CNT_W       = 16;
    localparam int LONG_HOLD   = 300;  // receiver hold-off that backs the block up
    localparam int BURST_TICKS = 12;   // gap-free ticks right after the first registrations
    localparam int RAND_ITEMS  = 140;

    // One result item as the block should present it.
    typedef struct packed {
        ptst_pkg::t_kind                kind;
        logic [ptst_pkg::OUT_ID_W-1:0]  fired_id;
        logic                           last;
    } t_timer_event;

    // Shadow copy of the slot table. note_item() advances it for each accepted input
    // and queues the result items that input causes; check_result() pops the oldest.
    class slot_table_checker;
        logic [ptst_pkg::IN_ID_W-1:0]  slot_id     [NUM_SLOTS];
        logic [ptst_pkg::PERIOD_W-1:0] slot_period [NUM_SLOTS];
        logic [CNT_W-1:0]              slot_count  [NUM_SLOTS];
        bit                            slot_on     [NUM_SLOTS];
        t_timer_event                  due_events[$];
        int                            errors;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_id[i]     = '0;
                slot_period[i] = '0;
                slot_count[i]  = '0;
                slot_on[i]     = 1'b0;
            end
            errors = 0;
        endfunction

        function int outstanding();
            return due_events.size();
        endfunction

        function void add_event(ptst_pkg::t_kind kind, logic [ptst_pkg::OUT_ID_W-1:0] id,
                                logic last);
            t_timer_event ev;
            ev.kind     = kind;
            ev.fired_id = id;
            ev.last     = last;
            due_events.push_back(ev);
        endfunction

        // first slot that is empty or already holds the id; NUM_SLOTS when none
        function int lookup_slot(logic [ptst_pkg::IN_ID_W-1:0] id);
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (slot_id[i] == '0 || slot_id[i] == id) return i;
            end
            return NUM_SLOTS;
        endfunction

        function void note_item(ptst_pkg::t_opcode op, logic [ptst_pkg::IN_ID_W-1:0] id,
                                logic [ptst_pkg::PERIOD_W-1:0] period, logic en_val);
            int s;
            case (op)
                ptst_pkg::OP_TICK: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (slot_id[i] != '0 && slot_period[i] <= slot_count[i] &&
                            slot_on[i]) begin
                            slot_count[i] = '0;
                            add_event(ptst_pkg::KIND_FIRED, slot_id[i], 1'b0);
                        end else if (slot_count[i] != '1) begin
                            slot_count[i] = slot_count[i] + 1'b1;
                        end
                    end
                    add_event(ptst_pkg::KIND_DONE, '0, 1'b1);
                end
                ptst_pkg::OP_REGISTER: begin
                    s = lookup_slot(id);
                    if (s == NUM_SLOTS) begin
                        add_event(ptst_pkg::KIND_OUT_OF_SLOTS, '0, 1'b1);
                    end else begin
                        slot_id[s]     = id;
                        slot_period[s] = period;
                        slot_count[s]  = '0;
                        slot_on[s]     = 1'b1;
                        add_event(ptst_pkg::KIND_REGISTERED, '0, 1'b1);
                    end
                end
                ptst_pkg::OP_ENABLE: begin
                    s = lookup_slot(id);
                    if (s != NUM_SLOTS) slot_on[s] = en_val;
                    add_event(ptst_pkg::KIND_ENABLE_DONE, '0, 1'b1);
                end
                default: ;  // unused opcode: no state change, no result
            endcase
        endfunction

        function void check_result(logic [ptst_pkg::KIND_W-1:0] kind,
                                   logic [ptst_pkg::OUT_ID_W-1:0] id, logic last);
            t_timer_event ev;
            if (due_events.size() == 0) begin
                $error("unexpected result item: kind %0d fired_id %0h last %0b",
                       kind, id, last);
                errors++;
                return;
            end
            ev = due_events.pop_front();
            if (kind !== ev.kind) begin
                $error("kind: expected %0d, actual %0d", ev.kind, kind);
                errors++;
            end
            if (id !== ev.fired_id) begin
                $error("fired_id: expected %0h, actual %0h", ev.fired_id, id);
                errors++;
            end
            if (last !== ev.last) begin
                $error("last: expected %0b, actual %0b", ev.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [ptst_pkg::OP_W-1:0]       i_opcode;
    logic [ptst_pkg::IN_ID_W-1:0]    i_timer_id;
    logic [ptst_pkg::PERIOD_W-1:0]   i_period_ticks;
    logic                            i_enable_value;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [ptst_pkg::KIND_W-1:0]     o_kind;
    logic [ptst_pkg::OUT_ID_W-1:0]   o_fired_id;
    logic                            o_last;

    slot_table_checker tracker;

    // burst_mode: both sides run without idle cycles.
    // hold_off: asks the receiver for one long stall; it clears the flag itself.
    bit burst_mode = 1'b0;
    bit hold_off   = 1'b0;

    periodic_timer_slot_table_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_timer_id     (i_timer_id),
        .i_period_ticks (i_period_ticks),
        .i_enable_value (i_enable_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_fired_id     (o_fired_id),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit: ends a run that hangs and reports it as failed.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Both handshakes are sampled at the rising edge. The result is checked before
    // the input is noted: a result seen at an edge never belongs to the item
    // accepted at that same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                tracker.check_result(o_kind, o_fired_id, o_last);
            if (i_in_valid && o_in_ready)
                tracker.note_item(ptst_pkg::t_opcode'(i_opcode), i_timer_id,
                                  i_period_ticks, i_enable_value);
        end
    end

    // Offer one item after a random gap; returns at the edge where it is taken.
    // Idle cycles carry junk payload so the block must qualify on valid.
    task automatic send_item(input ptst_pkg::t_opcode op,
                             input logic [ptst_pkg::IN_ID_W-1:0] id,
                             input logic [ptst_pkg::PERIOD_W-1:0] period,
                             input logic en_val);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid     = 1'b0;
            i_opcode       = ptst_pkg::OP_W'($urandom);
            i_timer_id     = ptst_pkg::IN_ID_W'($urandom);
            i_period_ticks = ptst_pkg::PERIOD_W'($urandom);
            i_enable_value = 1'($urandom);
        end
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_opcode       = op;
        i_timer_id     = id;
        i_period_ticks = period;
        i_enable_value = en_val;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Receiver: per result a random stall or none, or one long stall on
    // request. Ready is raised before valid shows up, so it never waits on valid.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off) begin
                hold_off = 1'b0;
                stall    = LONG_HOLD;
            end else begin
                stall = burst_mode ? 0 : $urandom_range(0, 6);
            end
            if (stall > 0) begin
                @(negedge i_clk);
                i_out_ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Stimulus
    initial begin
        // ids that the directed part leaves in the table, plus one that never fits
        logic [ptst_pkg::IN_ID_W-1:0] id_pool [11] = '{
            16'hFFFF, 16'h2C3D, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA,
            16'h1234, 16'h00FF, 16'hFF00, 16'h0F0F, 16'h7777};
        int                            sent;
        int                            roll;
        ptst_pkg::t_opcode             op;
        logic [ptst_pkg::IN_ID_W-1:0]  id_sel;
        logic [ptst_pkg::PERIOD_W-1:0] period_sel;

        tracker        = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_opcode       = ptst_pkg::OP_TICK;
        i_timer_id     = '0;
        i_period_ticks = '0;
        i_enable_value = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Slot 0 gets the largest period, slot 1 is live but disabled, the rest
        // stay empty. A short gap-free tick burst runs the counts up back to back.
        send_item(ptst_pkg::OP_REGISTER, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(ptst_pkg::OP_REGISTER, 16'h2C3D, 16'h0000, 1'b0);
        send_item(ptst_pkg::OP_ENABLE,   16'h2C3D, 16'h0000, 1'b0);
        burst_mode = 1'b1;
        repeat (BURST_TICKS)
            send_item(ptst_pkg::OP_TICK, ptst_pkg::IN_ID_W'($urandom),
                      ptst_pkg::PERIOD_W'($urandom), 1'($urandom));
        burst_mode = 1'b0;

        // Directed part. Zero id on register writes an empty slot that stays empty;
        // zero id on enable hits the first empty slot.
        send_item(ptst_pkg::OP_REGISTER, 16'h0000, 16'h0003, 1'b0);
        send_item(ptst_pkg::OP_ENABLE,   16'h0000, 16'h0000, 1'b0);
        // re-enabling the disabled slot makes it fire on the next tick
        send_item(ptst_pkg::OP_ENABLE,   16'h2C3D, 16'h0000, 1'b1);
        send_item(ptst_pkg::OP_TICK,     16'h0000, 16'h0000, 1'b0);
        send_item(ptst_pkg::OP_REGISTER, 16'h0001, 16'h0000, 1'b0);
        send_item(ptst_pkg::OP_REGISTER, 16'h8000, 16'h0001, 1'b1);
        send_item(ptst_pkg::OP_TICK,     16'hFFFF, 16'hFFFF, 1'b1);
        // fill the remaining slots
        send_item(ptst_pkg::OP_REGISTER, 16'h5555, 16'h0002, 1'b0);
        send_item(ptst_pkg::OP_REGISTER, 16'hAAAA, 16'h0004, 1'b1);
        send_item(ptst_pkg::OP_REGISTER, 16'h1234, 16'h0003, 1'b0);
        send_item(ptst_pkg::OP_REGISTER, 16'h00FF, 16'h0000, 1'b1);
        send_item(ptst_pkg::OP_REGISTER, 16'hFF00, 16'h0001, 1'b0);
        send_item(ptst_pkg::OP_REGISTER, 16'h0F0F, 16'h0002, 1'b1);
        // table full: register is refused, enable finds nothing to change
        send_item(ptst_pkg::OP_REGISTER, 16'h7777, 16'h0001, 1'b1);
        send_item(ptst_pkg::OP_ENABLE,   16'h7777, 16'h0000, 1'b1);
        send_item(ptst_pkg::OP_ENABLE,   16'h0000, 16'h0000, 1'b1);
        // re-register an existing id, disable another
        send_item(ptst_pkg::OP_REGISTER, 16'h8000, 16'h0000, 1'b0);
        send_item(ptst_pkg::OP_ENABLE,   16'h0001, 16'h0000, 1'b0);
        send_item(ptst_pkg::OP_TICK,     16'h0000, 16'h0000, 1'b0);
        send_item(ptst_pkg::OP_TICK,     16'h0000, 16'h0000, 1'b0);
        // drop the full-scale period so every slot can come due together
        send_item(ptst_pkg::OP_REGISTER, 16'hFFFF, 16'h0000, 1'b0);
        send_item(ptst_pkg::OP_ENABLE,   16'h0001, 16'h0000, 1'b1);
        send_item(ptst_pkg::OP_TICK,     16'h0000, 16'h0000, 1'b0);
        send_item(ptst_pkg::OP_TICK,     16'h0000, 16'h0000, 1'b0);
        send_item(ptst_pkg::OP_NOP,      16'hFFFF, 16'hFFFF, 1'b1);
        send_item(ptst_pkg::OP_TICK,     16'h0000, 16'h0000, 1'b0);

        // Random part: mostly ticks and lookups on known ids with short periods so
        // that slots keep firing; some zero or random ids and full-range periods.
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (sent == 60) hold_off = 1'b1;          // long receiver stall ...
            burst_mode = (sent >= 110 && sent < 130);   // ... and a gap-free stretch
            roll = $urandom_range(0, 99);
            if (sent >= 60 && sent < 72) roll = 0;      // ticks pile up behind the stall
            if (roll < 50)      op = ptst_pkg::OP_TICK;
            else if (roll < 75) op = ptst_pkg::OP_REGISTER;
            else if (roll < 95) op = ptst_pkg::OP_ENABLE;
            else                op = ptst_pkg::OP_NOP;

            roll = $urandom_range(0, 9);
            if (roll < 8)       id_sel = id_pool[$urandom_range(0, 10)];
            else if (roll == 8) id_sel = '0;
            else                id_sel = ptst_pkg::IN_ID_W'($urandom);

            period_sel = ($urandom_range(0, 9) == 0)
                       ? ptst_pkg::PERIOD_W'($urandom)
                       : ptst_pkg::PERIOD_W'($urandom_range(0, 4));
            send_item(op, id_sel, period_sel, 1'($urandom_range(0, 1)));
            if (op != ptst_pkg::OP_NOP) sent++;
        end
        burst_mode = 1'b0;

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        // any result that arrives in this closing window is flagged as unexpected
        repeat (40) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== periodic_timer_slot_table_core.f =====
+incdir+hw/rtl
hw/rtl/ptst_pkg.sv
hw/rtl/ptst_ram.sv
hw/rtl/ptst_ctrl.sv
hw/rtl/ptst_datapath.sv
hw/rtl/periodic_timer_slot_table_core.sv
tb/sv/tb_top.sv
